FILE: design/rrip_pkg.sv
// Shared types and constants for the RRIP cache tag array.
// No dependencies; imported by the top level.
package rrip_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } rrip_state_t;

  // Insertion mode codes
  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_BIMODAL = 2'd1,
    MODE_SPLIT   = 2'd2,
    MODE_SPARE   = 2'd3
  } rrip_mode_t;

  // Prediction values
  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd1;
  localparam logic [1:0] RRPV_HIT  = 2'd0;

  // Miss counter: wraps at 32, split mode inserts near below this point
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] SPLIT_POINT = 5'd16;

  // Result field width for the way number
  localparam int unsigned WAY_OUT_W = 3;

endpackage

FILE: design/rrip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instantiated by the RRIP tag array top level.
module rrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rrip_set_assoc_cache_tags.sv
// Set-associative cache tag array with RRIP replacement (static, bimodal, split).
// Depends on rrip_pkg and rrip_ram (one row per set holding all ways).
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+-----------
//  input   | in_address                             | in        | in_valid/in_ready
//  result  | out_hit, out_way_used, out_*_total     | out       | out_valid/out_ready
//  config  | cfg_wdata (insertion mode)             | in        | cfg_we, no wait
//
// For each item the set's row is read from the tag RAM at the accepting edge,
// then in ST_LOOK compared, promoted on a hit or aged on a miss, and written
// back once the result register is free, which also loads that register. The
// single RAM read-modify-write of one set means no new item is taken until the
// last is written back; a stalled result holds the block in ST_LOOK meanwhile.
// After reset a clearing pass writes every row with in_ready low.
module rrip_set_assoc_cache_tags
  import rrip_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_BITS-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [2:0]           out_way_used,
  output logic [31:0]          out_hit_total,
  output logic [31:0]          out_miss_total
);

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int SET_B   = $clog2(SETS);
  localparam int SET_W   = (SET_B > 0) ? SET_B : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_RAW = ADDR_BITS - OFF_W - SET_B;
  localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int ENTRY_W = TAG_W + 3;
  localparam int ROW_W   = ENTRY_W * WAYS;

  rrip_state_t state_r, state_nxt;

  logic [SET_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [1:0]       mode_r;
  logic [CNT_W-1:0] ins_cnt_r;
  logic [31:0]      hit_cnt_r;
  logic [31:0]      miss_cnt_r;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [2:0]       out_way_r;

  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  logic             mem_re;
  logic             mem_we;
  logic             do_load;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] clr_row;

  logic [TAG_W-1:0] way_tag [WAYS];
  logic             way_vld [WAYS];
  logic [1:0]       way_rr  [WAYS];
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] used_way;
  logic [1:0]       top_rr;
  logic [1:0]       ins_rr;
  logic             cnt_step;

  // Split the address into set index and tag
  generate
    if (SET_B > 0) begin : g_set
      assign in_set = SET_W'(in_address >> OFF_W);
    end else begin : g_noset
      assign in_set = '0;
    end
  endgenerate
  assign in_tag = TAG_W'(in_address >> (OFF_W + SET_B));

  // Next state
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready = 1'b0;
    do_load  = 1'b0;
    mem_we   = 1'b0;
    case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_LOOK: begin
        do_load = !out_valid_r || out_ready;
        mem_we  = do_load;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign mem_re    = in_valid && in_ready;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : set_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? clr_row : upd_row;

  rrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_set),
    .rdata (rd_row)
  );

  // Unpack the set row; build the cleared row
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      way_tag[i] = rd_row[i*ENTRY_W+3 +: TAG_W];
      way_vld[i] = rd_row[i*ENTRY_W+2];
      way_rr[i]  = rd_row[i*ENTRY_W +: 2];
      clr_row[i*ENTRY_W +: ENTRY_W] = {{TAG_W{1'b0}}, 1'b0, RRPV_MAX};
    end
  end

  // Tag compare: lowest matching valid way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (way_vld[i] && (way_tag[i] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
  end

  // Victim: first way holding the largest value, which aging lifts to max
  always_comb begin
    top_rr = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (way_rr[i] > top_rr) begin
        top_rr = way_rr[i];
      end
    end
    vic_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (way_rr[i] == top_rr) begin
        vic_way = WAY_W'(i);
      end
    end
  end

  // Insertion value and counter step
  always_comb begin
    ins_rr   = RRPV_MAX;
    cnt_step = 1'b0;
    case (rrip_mode_t'(mode_r))
      MODE_BIMODAL: begin
        ins_rr   = (ins_cnt_r == '0) ? RRPV_NEAR : RRPV_MAX;
        cnt_step = 1'b1;
      end
      MODE_SPLIT: begin
        ins_rr   = (ins_cnt_r < SPLIT_POINT) ? RRPV_NEAR : RRPV_MAX;
        cnt_step = 1'b1;
      end
      default: begin
        ins_rr   = RRPV_MAX;
        cnt_step = 1'b0;
      end
    endcase
  end

  // Modified row: promote the hit way, or age the set and fill the victim
  always_comb begin
    upd_row = rd_row;
    for (int i = 0; i < WAYS; i++) begin
      if (hit) begin
        if (hit_way == WAY_W'(i)) begin
          upd_row[i*ENTRY_W +: 2] = RRPV_HIT;
        end
      end else if (vic_way == WAY_W'(i)) begin
        upd_row[i*ENTRY_W +: ENTRY_W] = {tag_r, 1'b1, ins_rr};
      end else begin
        upd_row[i*ENTRY_W +: 2] = way_rr[i] + (RRPV_MAX - top_rr);
      end
    end
  end

  assign used_way = hit ? hit_way : vic_way;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      mode_r      <= MODE_STATIC;
      ins_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
        if (hit) begin
          hit_cnt_r <= hit_cnt_r + 32'd1;
        end else begin
          miss_cnt_r <= miss_cnt_r + 32'd1;
          if (cnt_step) begin
            ins_cnt_r <= ins_cnt_r + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (mem_re) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
    if (do_load) begin
      out_hit_r <= hit;
      out_way_r <= WAY_OUT_W'(used_way);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_LOOK))
    else $error("accepted item did not move to lookup");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result load did not present a result");

  a_totals_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!do_load && (state_r != ST_CLEAR)) |=> ($stable(hit_cnt_r) && $stable(miss_cnt_r)))
    else $error("totals changed without a result");
`endif

endmodule
